// File: design/sha256_pkg.sv
// ============================================================================
// sha256_pkg
// shared types, sizes, round constants and mixing functions for the
// streaming sha-256 core
// ============================================================================
package sha256_pkg;

    typedef logic [31:0] word_t;
    typedef logic [7:0]  byte_t;
    typedef logic [2:0]  dig_index_t;

    localparam int BLOCK_WORDS = 16;
    localparam int BLOCK_BYTES = 64;
    localparam int CHAIN_WORDS = 8;
    localparam int ROUNDS      = 64;
    localparam int LEN_BYTES   = 8;
    localparam int BYTE_CNT_W  = 61;

    localparam byte_t PAD_MARKER = 8'h80;

    function automatic word_t rotr(input word_t x, input int unsigned n);
        begin
            rotr = (x >> n) | (x << (32 - n));
        end
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        begin
            big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
        end
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        begin
            big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
        end
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        begin
            small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
        end
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        begin
            small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
        end
    endfunction

    // initial hash values
    function automatic word_t init_hash(input logic [2:0] idx);
        begin
            case (idx)
                3'd0:    init_hash = 32'h6a09e667;
                3'd1:    init_hash = 32'hbb67ae85;
                3'd2:    init_hash = 32'h3c6ef372;
                3'd3:    init_hash = 32'ha54ff53a;
                3'd4:    init_hash = 32'h510e527f;
                3'd5:    init_hash = 32'h9b05688c;
                3'd6:    init_hash = 32'h1f83d9ab;
                3'd7:    init_hash = 32'h5be0cd19;
                default: init_hash = 32'h6a09e667;
            endcase
        end
    endfunction

    // round constants
    function automatic word_t round_k(input logic [5:0] idx);
        begin
            case (idx)
                6'd0:    round_k = 32'h428a2f98;
                6'd1:    round_k = 32'h71374491;
                6'd2:    round_k = 32'hb5c0fbcf;
                6'd3:    round_k = 32'he9b5dba5;
                6'd4:    round_k = 32'h3956c25b;
                6'd5:    round_k = 32'h59f111f1;
                6'd6:    round_k = 32'h923f82a4;
                6'd7:    round_k = 32'hab1c5ed5;
                6'd8:    round_k = 32'hd807aa98;
                6'd9:    round_k = 32'h12835b01;
                6'd10:   round_k = 32'h243185be;
                6'd11:   round_k = 32'h550c7dc3;
                6'd12:   round_k = 32'h72be5d74;
                6'd13:   round_k = 32'h80deb1fe;
                6'd14:   round_k = 32'h9bdc06a7;
                6'd15:   round_k = 32'hc19bf174;
                6'd16:   round_k = 32'he49b69c1;
                6'd17:   round_k = 32'hefbe4786;
                6'd18:   round_k = 32'h0fc19dc6;
                6'd19:   round_k = 32'h240ca1cc;
                6'd20:   round_k = 32'h2de92c6f;
                6'd21:   round_k = 32'h4a7484aa;
                6'd22:   round_k = 32'h5cb0a9dc;
                6'd23:   round_k = 32'h76f988da;
                6'd24:   round_k = 32'h983e5152;
                6'd25:   round_k = 32'ha831c66d;
                6'd26:   round_k = 32'hb00327c8;
                6'd27:   round_k = 32'hbf597fc7;
                6'd28:   round_k = 32'hc6e00bf3;
                6'd29:   round_k = 32'hd5a79147;
                6'd30:   round_k = 32'h06ca6351;
                6'd31:   round_k = 32'h14292967;
                6'd32:   round_k = 32'h27b70a85;
                6'd33:   round_k = 32'h2e1b2138;
                6'd34:   round_k = 32'h4d2c6dfc;
                6'd35:   round_k = 32'h53380d13;
                6'd36:   round_k = 32'h650a7354;
                6'd37:   round_k = 32'h766a0abb;
                6'd38:   round_k = 32'h81c2c92e;
                6'd39:   round_k = 32'h92722c85;
                6'd40:   round_k = 32'ha2bfe8a1;
                6'd41:   round_k = 32'ha81a664b;
                6'd42:   round_k = 32'hc24b8b70;
                6'd43:   round_k = 32'hc76c51a3;
                6'd44:   round_k = 32'hd192e819;
                6'd45:   round_k = 32'hd6990624;
                6'd46:   round_k = 32'hf40e3585;
                6'd47:   round_k = 32'h106aa070;
                6'd48:   round_k = 32'h19a4c116;
                6'd49:   round_k = 32'h1e376c08;
                6'd50:   round_k = 32'h2748774c;
                6'd51:   round_k = 32'h34b0bcb5;
                6'd52:   round_k = 32'h391c0cb3;
                6'd53:   round_k = 32'h4ed8aa4a;
                6'd54:   round_k = 32'h5b9cca4f;
                6'd55:   round_k = 32'h682e6ff3;
                6'd56:   round_k = 32'h748f82ee;
                6'd57:   round_k = 32'h78a5636f;
                6'd58:   round_k = 32'h84c87814;
                6'd59:   round_k = 32'h8cc70208;
                6'd60:   round_k = 32'h90befffa;
                6'd61:   round_k = 32'ha4506ceb;
                6'd62:   round_k = 32'hbef9a3f7;
                6'd63:   round_k = 32'hc67178f2;
                default: round_k = 32'h428a2f98;
            endcase
        end
    endfunction

endpackage

// File: design/sha256_ifs.sv
// ============================================================================
// sha256 channel interfaces
// valid/ready channels for message bytes and digest words
// ============================================================================
interface sha256_msg_if;
    logic                valid;
    logic                ready;
    sha256_pkg::byte_t   data_byte;
    logic                byte_valid;
    logic                end_of_message;

    modport source (output valid, output data_byte, output byte_valid,
                    output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input byte_valid,
                    input end_of_message, output ready);
endinterface

interface sha256_dig_if;
    logic                   valid;
    logic                   ready;
    sha256_pkg::word_t      digest_word;
    sha256_pkg::dig_index_t word_index;
    logic                   last_word;
    logic                   too_long;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, output too_long, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input last_word, input too_long, output ready);
endinterface

// File: design/sha256_message_digest_core.sv
// ============================================================================
// sha256_message_digest_core
// streaming sha-256: bytes in, eight digest words out per message
// ============================================================================
// Each input word carries at most one message byte and an end-of-message
// mark. Bytes are packed big-endian into a 16-entry block memory at one
// byte per cycle. When the 64th byte of a block arrives, input is held off
// while the chaining state is read from an 8-entry memory, the 64 rounds
// run on a single round unit (message words come from the block memory for
// rounds 0..15 and from a 16-word schedule line afterwards), and the
// result is added back into the chaining memory. At end of message a
// padding sweep writes the 0x80 marker, zeros and the 64-bit bit length
// into the block memory from the marker's word on, followed by one
// compression, or two if 8 or fewer byte slots remained. The eight digest
// words then leave one at a time, each read from the chaining memory into
// the output register and held until the consumer takes it, and the block
// is ready for the next message. No clearing pass is needed after reset:
// the first block of each message takes the initial hash values from a
// constant table instead of the chaining memory. Messages of 2^61 bytes
// or more wrap the length and mark every digest word with too_long.
// ============================================================================
module sha256_message_digest_core (
    input  logic              clk,
    input  logic              rst_n,
    sha256_msg_if.sink        msg,
    sha256_dig_if.source      digest
);

    typedef enum logic [2:0] {
        S_IDLE,     // taking message bytes
        S_PAD,      // padding sweep over the block memory
        S_LOAD,     // chaining state into working registers
        S_ROUND,    // 64 compression rounds
        S_FIN,      // add working registers into chaining state
        S_ORD,      // read a digest word
        S_OLD,      // load the output register
        S_OWT       // wait for the consumer
    } state_t;

    localparam logic [3:0] STEP_LAST   = 4'(sha256_pkg::CHAIN_WORDS);
    localparam logic [5:0] ROUND_LAST  = 6'(sha256_pkg::ROUNDS - 1);
    localparam logic [5:0] POS_LAST    = 6'(sha256_pkg::BLOCK_BYTES - 1);
    localparam logic [5:0] PAD_LIMIT   = 6'(sha256_pkg::BLOCK_BYTES - sha256_pkg::LEN_BYTES);
    localparam logic [3:0] BLK_LAST    = 4'(sha256_pkg::BLOCK_WORDS - 1);
    localparam logic [3:0] LEN_HI_IDX  = 4'(sha256_pkg::BLOCK_WORDS - 2);
    localparam logic [2:0] DIG_LAST    = 3'(sha256_pkg::CHAIN_WORDS - 1);
    localparam int         CW          = sha256_pkg::BYTE_CNT_W;

    // memories
    sha256_pkg::word_t blk_mem   [sha256_pkg::BLOCK_WORDS];
    sha256_pkg::word_t chain_mem [sha256_pkg::CHAIN_WORDS];
    sha256_pkg::word_t blk_q_reg;
    sha256_pkg::word_t chain_q_reg;

    logic              blk_we;
    logic [3:0]        blk_waddr;
    sha256_pkg::word_t blk_wdata;
    logic [3:0]        blk_raddr;
    logic              chain_we;
    logic [2:0]        chain_waddr;
    sha256_pkg::word_t chain_wdata;
    logic [2:0]        chain_raddr;

    // control
    state_t            state_reg, state_next;
    logic [3:0]        step_reg, step_next;
    logic [5:0]        round_reg, round_next;
    logic [3:0]        pad_idx_reg, pad_idx_next;
    logic [3:0]        pad_start_reg, pad_start_next;
    logic [1:0]        pad_lane_reg, pad_lane_next;
    logic              first_sweep_reg, first_sweep_next;
    logic              need_extra_reg, need_extra_next;
    logic              padded_reg, padded_next;
    logic              end_pend_reg, end_pend_next;
    logic              first_blk_reg, first_blk_next;
    logic [CW-1:0]     byte_cnt_reg, byte_cnt_next;
    logic              overflow_reg, overflow_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    sha256_pkg::word_t out_word_reg, out_word_next;
    logic [2:0]        out_idx_reg, out_idx_next;
    logic              out_last_reg, out_last_next;
    logic              out_long_reg, out_long_next;

    // datapath
    sha256_pkg::word_t pack_reg, pack_next;
    sha256_pkg::word_t v_reg [sha256_pkg::CHAIN_WORDS];
    sha256_pkg::word_t v_next [sha256_pkg::CHAIN_WORDS];
    sha256_pkg::word_t sched_reg [sha256_pkg::BLOCK_WORDS];
    sha256_pkg::word_t sched_next [sha256_pkg::BLOCK_WORDS];
    sha256_pkg::word_t wsch_reg, wsch_next;

    logic              accept;
    logic [5:0]        pos;
    logic [1:0]        lane;
    sha256_pkg::word_t byte_word;
    sha256_pkg::word_t pack_new;
    logic [CW:0]       cnt_inc;
    logic [CW-1:0]     cnt_after;
    logic [5:0]        pad_pos;
    logic              start_pad;
    sha256_pkg::word_t marker;
    sha256_pkg::word_t pad_word;
    sha256_pkg::word_t pad_data;
    logic              len_block;
    sha256_pkg::word_t chain_base;
    sha256_pkg::word_t w_cur;
    sha256_pkg::word_t t1;
    sha256_pkg::word_t t2;
    sha256_pkg::word_t ch;
    sha256_pkg::word_t maj;
    sha256_pkg::word_t load_val;

    assign accept = msg.valid && msg.ready;

    // byte packing, big-endian within each word
    assign pos       = byte_cnt_reg[5:0];
    assign lane      = pos[1:0];
    assign byte_word = 32'(msg.data_byte) << {~lane, 3'b000};
    assign pack_new  = (lane == 2'd0) ? byte_word : (pack_reg | byte_word);
    assign cnt_inc   = {1'b0, byte_cnt_reg} + {{CW{1'b0}}, 1'b1};
    assign cnt_after = msg.byte_valid ? cnt_inc[CW-1:0] : byte_cnt_reg;

    // padding starts at the position after any byte of this word
    assign pad_pos = (state_reg == S_IDLE) ? cnt_after[5:0] : byte_cnt_reg[5:0];

    // padding sweep data
    assign marker    = 32'(sha256_pkg::PAD_MARKER) << {~pad_lane_reg, 3'b000};
    assign pad_word  = (pad_lane_reg == 2'd0) ? marker : (pack_reg | marker);
    assign len_block = !(first_sweep_reg && need_extra_reg);

    always_comb
    begin
        if (first_sweep_reg && (pad_idx_reg == pad_start_reg))
        begin
            pad_data = pad_word;
        end
        else if (len_block && (pad_idx_reg == LEN_HI_IDX))
        begin
            pad_data = byte_cnt_reg[CW-1:CW-32];
        end
        else if (len_block && (pad_idx_reg == BLK_LAST))
        begin
            pad_data = {byte_cnt_reg[CW-33:0], 3'b000};
        end
        else
        begin
            pad_data = '0;
        end
    end

    // chaining value seen by load and write-back; first block uses the table
    assign chain_base = first_blk_reg ? sha256_pkg::init_hash(step_reg[2:0] - 3'd1)
                                      : chain_q_reg;

    // control sequencer
    always_comb
    begin
        state_next       = state_reg;
        step_next        = step_reg;
        round_next       = round_reg;
        pad_idx_next     = pad_idx_reg;
        pad_start_next   = pad_start_reg;
        pad_lane_next    = pad_lane_reg;
        first_sweep_next = first_sweep_reg;
        need_extra_next  = need_extra_reg;
        padded_next      = padded_reg;
        end_pend_next    = end_pend_reg;
        first_blk_next   = first_blk_reg;
        byte_cnt_next    = byte_cnt_reg;
        overflow_next    = overflow_reg;
        out_valid_next   = out_valid_reg;
        out_word_next    = out_word_reg;
        out_idx_next     = out_idx_reg;
        out_last_next    = out_last_reg;
        out_long_next    = out_long_reg;
        start_pad        = 1'b0;
        blk_we           = 1'b0;
        blk_waddr        = pos[5:2];
        blk_wdata        = pack_new;
        blk_raddr        = '0;
        chain_we         = 1'b0;
        chain_waddr      = step_reg[2:0] - 3'd1;
        chain_wdata      = chain_base + v_reg[0];
        chain_raddr      = step_reg[2:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (msg.byte_valid)
                    begin
                        blk_we        = (lane == 2'd3);
                        byte_cnt_next = cnt_inc[CW-1:0];
                        if (cnt_inc[CW])
                        begin
                            overflow_next = 1'b1;
                        end
                    end
                    if (msg.byte_valid && (pos == POS_LAST))
                    begin
                        state_next    = S_LOAD;
                        step_next     = '0;
                        end_pend_next = msg.end_of_message;
                    end
                    else if (msg.end_of_message)
                    begin
                        start_pad = 1'b1;
                    end
                end
            end

            S_PAD:
            begin
                blk_we    = 1'b1;
                blk_waddr = pad_idx_reg;
                blk_wdata = pad_data;
                if (pad_idx_reg == BLK_LAST)
                begin
                    state_next = S_LOAD;
                    step_next  = '0;
                end
                else
                begin
                    pad_idx_next = pad_idx_reg + 4'd1;
                end
            end

            S_LOAD:
            begin
                if (step_reg == STEP_LAST)
                begin
                    state_next = S_ROUND;
                    round_next = '0;
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            end

            S_ROUND:
            begin
                blk_raddr = round_reg[3:0] + 4'd1;
                if (round_reg == ROUND_LAST)
                begin
                    state_next = S_FIN;
                    step_next  = '0;
                end
                else
                begin
                    round_next = round_reg + 6'd1;
                end
            end

            S_FIN:
            begin
                chain_we = (step_reg != 4'd0);
                if (step_reg == STEP_LAST)
                begin
                    first_blk_next = 1'b0;
                    if (!end_pend_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (!padded_reg)
                    begin
                        start_pad = 1'b1;
                    end
                    else if (first_sweep_reg && need_extra_reg)
                    begin
                        // length did not fit: second block of zeros and length
                        state_next       = S_PAD;
                        pad_idx_next     = '0;
                        first_sweep_next = 1'b0;
                    end
                    else
                    begin
                        state_next   = S_ORD;
                        out_idx_next = '0;
                    end
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            end

            S_ORD:
            begin
                chain_raddr = out_idx_reg;
                state_next  = S_OLD;
            end

            S_OLD:
            begin
                out_valid_next = 1'b1;
                out_word_next  = chain_q_reg;
                out_last_next  = (out_idx_reg == DIG_LAST);
                out_long_next  = overflow_reg;
                state_next     = S_OWT;
            end

            S_OWT:
            begin
                if (digest.ready)
                begin
                    out_valid_next = 1'b0;
                    if (out_idx_reg == DIG_LAST)
                    begin
                        state_next     = S_IDLE;
                        byte_cnt_next  = '0;
                        overflow_next  = 1'b0;
                        first_blk_next = 1'b1;
                        end_pend_next  = 1'b0;
                        padded_next    = 1'b0;
                    end
                    else
                    begin
                        out_idx_next = out_idx_reg + 3'd1;
                        state_next   = S_ORD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (start_pad)
        begin
            state_next       = S_PAD;
            pad_idx_next     = pad_pos[5:2];
            pad_start_next   = pad_pos[5:2];
            pad_lane_next    = pad_pos[1:0];
            first_sweep_next = 1'b1;
            need_extra_next  = (pad_pos >= PAD_LIMIT);
            padded_next      = 1'b1;
            end_pend_next    = 1'b1;
        end
    end

    // round unit and message schedule
    assign w_cur = (round_reg[5:4] == 2'd0) ? blk_q_reg : wsch_reg;
    assign ch    = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign maj   = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t1    = v_reg[7] + sha256_pkg::big_sigma1(v_reg[4]) + ch
                   + sha256_pkg::round_k(round_reg) + w_cur;
    assign t2    = sha256_pkg::big_sigma0(v_reg[0]) + maj;
    assign load_val = chain_base;

    always_comb
    begin
        pack_next  = pack_reg;
        wsch_next  = wsch_reg;
        v_next     = v_reg;
        sched_next = sched_reg;

        if ((state_reg == S_IDLE) && accept && msg.byte_valid)
        begin
            pack_next = pack_new;
        end

        case (state_reg)
            S_LOAD, S_FIN:
            begin
                // working registers shift towards entry 0 as words pass
                if (step_reg != 4'd0)
                begin
                    for (int i = 0; i < sha256_pkg::CHAIN_WORDS - 1; i++)
                    begin
                        v_next[i] = v_reg[i + 1];
                    end
                    v_next[sha256_pkg::CHAIN_WORDS - 1] = load_val;
                end
            end

            S_ROUND:
            begin
                v_next[7] = v_reg[6];
                v_next[6] = v_reg[5];
                v_next[5] = v_reg[4];
                v_next[4] = v_reg[3] + t1;
                v_next[3] = v_reg[2];
                v_next[2] = v_reg[1];
                v_next[1] = v_reg[0];
                v_next[0] = t1 + t2;
                for (int j = 0; j < sha256_pkg::BLOCK_WORDS - 1; j++)
                begin
                    sched_next[j] = sched_reg[j + 1];
                end
                sched_next[sha256_pkg::BLOCK_WORDS - 1] = w_cur;
                // schedule word for the next round
                wsch_next = sha256_pkg::small_sigma1(sched_reg[15]) + sched_reg[10]
                            + sha256_pkg::small_sigma0(sched_reg[2]) + sched_reg[1];
            end

            default:
            begin
                wsch_next = wsch_reg;
            end
        endcase
    end

    // control and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            step_reg        <= '0;
            round_reg       <= '0;
            pad_idx_reg     <= '0;
            pad_start_reg   <= '0;
            pad_lane_reg    <= '0;
            first_sweep_reg <= 1'b0;
            need_extra_reg  <= 1'b0;
            padded_reg      <= 1'b0;
            end_pend_reg    <= 1'b0;
            first_blk_reg   <= 1'b1;
            byte_cnt_reg    <= '0;
            overflow_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_word_reg    <= '0;
            out_idx_reg     <= '0;
            out_last_reg    <= 1'b0;
            out_long_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            step_reg        <= step_next;
            round_reg       <= round_next;
            pad_idx_reg     <= pad_idx_next;
            pad_start_reg   <= pad_start_next;
            pad_lane_reg    <= pad_lane_next;
            first_sweep_reg <= first_sweep_next;
            need_extra_reg  <= need_extra_next;
            padded_reg      <= padded_next;
            end_pend_reg    <= end_pend_next;
            first_blk_reg   <= first_blk_next;
            byte_cnt_reg    <= byte_cnt_next;
            overflow_reg    <= overflow_next;
            out_valid_reg   <= out_valid_next;
            out_word_reg    <= out_word_next;
            out_idx_reg     <= out_idx_next;
            out_last_reg    <= out_last_next;
            out_long_reg    <= out_long_next;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        pack_reg  <= pack_next;
        wsch_reg  <= wsch_next;
        v_reg     <= v_next;
        sched_reg <= sched_next;
    end

    // block memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (blk_we)
        begin
            blk_mem[blk_waddr] <= blk_wdata;
        end
        blk_q_reg <= blk_mem[blk_raddr];
    end

    // chaining memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (chain_we)
        begin
            chain_mem[chain_waddr] <= chain_wdata;
        end
        chain_q_reg <= chain_mem[chain_raddr];
    end

    assign msg.ready          = (state_reg == S_IDLE);
    assign digest.valid       = out_valid_reg;
    assign digest.digest_word = out_word_reg;
    assign digest.word_index  = out_idx_reg;
    assign digest.last_word   = out_last_reg;
    assign digest.too_long    = out_long_reg;

endmodule

// File: design/sha256_chk.sv
// ============================================================================
// sha256_chk
// port-level checks on the sha-256 core, bound to the top level
// ============================================================================
module sha256_chk (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   msg_valid,
    input  logic                   msg_ready,
    input  logic                   dig_valid,
    input  logic                   dig_ready,
    input  sha256_pkg::word_t      dig_word,
    input  sha256_pkg::dig_index_t dig_index,
    input  logic                   dig_last,
    input  logic                   dig_long
);

    localparam logic [2:0] LAST_INDEX = 3'(sha256_pkg::CHAIN_WORDS - 1);

    // last mark only on the final digest word
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        dig_valid |-> (dig_last == (dig_index == LAST_INDEX)))
        else $error("last_word does not match word_index");

    // no message word taken while a digest word is pending
    a_no_input_in_digest: assert property (@(posedge clk) disable iff (!rst_n)
        dig_valid |-> !msg_ready)
        else $error("input accepted during digest output");

    // stalled digest word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dig_valid && !dig_ready |=> dig_valid && $stable(dig_word)
                                    && $stable(dig_index) && $stable(dig_long))
        else $error("digest word changed while stalled");

    // ready for the next message straight after the last digest word
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        dig_valid && dig_ready && dig_last |=> msg_ready && !dig_valid)
        else $error("core not ready after last digest word");

    // input stays closed after a non-final digest word is taken while a message word waits
    a_long_steady: assert property (@(posedge clk) disable iff (!rst_n)
        dig_valid && dig_ready && !dig_last && msg_valid |=> !msg_ready)
        else $error("core left digest output early");

endmodule

bind sha256_message_digest_core sha256_chk u_sha256_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .msg_valid (msg.valid),
    .msg_ready (msg.ready),
    .dig_valid (digest.valid),
    .dig_ready (digest.ready),
    .dig_word  (digest.digest_word),
    .dig_index (digest.word_index),
    .dig_last  (digest.last_word),
    .dig_long  (digest.too_long)
);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// self-checking bench for the streaming sha-256 core: message bytes go in
// one word at a time, every accepted word runs through a bench-side digest
// model, and each digest word that comes out is checked against the oldest
// expected word. short directed messages come first, then random messages
// with byte-side idle gaps, digest-side stalls, both or neither.
// ============================================================================
module tb_top;

    // one word on the byte channel
    typedef struct packed {
        sha256_pkg::byte_t data;
        logic              has_byte;
        logic              eom;
    } msg_word_t;

    // one expected word on the digest channel
    typedef struct packed {
        sha256_pkg::word_t      value;
        sha256_pkg::dig_index_t index;
        logic                   last;
        logic                   too_long;
    } digest_rec_t;

    // round constants and initial hash, word 0 in the top bits
    localparam logic [64*32-1:0] ROUND_KEYS = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam logic [8*32-1:0] HASH_IV = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // non-idle words per random phase; the last message overshoots a little
    localparam int PHASE_WORDS  = 38;
    localparam int SETTLE_CYCLES = 200;

    logic clk;
    logic rst_n;

    sha256_msg_if msg_ch ();
    sha256_dig_if dig_ch ();

    sha256_message_digest_core i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg_ch),
        .digest (dig_ch)
    );

    // ------------------------------------------------------------------------
    // digest model state
    // ------------------------------------------------------------------------
    sha256_pkg::word_t hash_chain [8];
    sha256_pkg::word_t msg_block [16];
    logic [63:0]       msg_bits;
    logic              len_wrapped;

    digest_rec_t digest_expect_q [$];
    msg_word_t   pending_words [$];

    // idling controls, changed only between phases
    int unsigned idle_pct;
    int unsigned stall_pct;

    // run statistics
    int unsigned queued_words;
    int unsigned bytes_hashed;
    int unsigned digests_made;
    int unsigned words_checked;
    int unsigned fails;

    // set at the rising edge when a byte-side word has been taken
    bit msg_word_taken;

    function automatic sha256_pkg::word_t ror32(sha256_pkg::word_t x, int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void load_iv();
        for (int i = 0; i < 8; i++)
        begin
            hash_chain[i] = HASH_IV[(7 - i)*32 +: 32];
        end
        msg_bits    = '0;
        len_wrapped = 1'b0;
    endfunction

    // one 64-round compression of msg_block into hash_chain
    function automatic void mix_block();
        sha256_pkg::word_t sched [64];
        sha256_pkg::word_t v [8];
        sha256_pkg::word_t p, q, s0, s1, t1, t2, ch, maj;
        for (int i = 0; i < 16; i++)
        begin
            sched[i] = msg_block[i];
        end
        for (int i = 16; i < 64; i++)
        begin
            p  = sched[i-15];
            q  = sched[i-2];
            s0 = ror32(p, 7) ^ ror32(p, 18) ^ (p >> 3);
            s1 = ror32(q, 17) ^ ror32(q, 19) ^ (q >> 10);
            sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
        end
        for (int i = 0; i < 8; i++)
        begin
            v[i] = hash_chain[i];
        end
        for (int i = 0; i < 64; i++)
        begin
            s1  = ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25);
            ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
            t1  = v[7] + s1 + ch + ROUND_KEYS[(63 - i)*32 +: 32] + sched[i];
            s0  = ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22);
            maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
            t2  = s0 + maj;
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
        begin
            hash_chain[i] = hash_chain[i] + v[i];
        end
    endfunction

    // advance the digest model by one accepted word
    function automatic void absorb_word(sha256_pkg::byte_t b, logic has_b, logic eom);
        int unsigned pos;
        int unsigned widx;
        int unsigned lane;
        digest_rec_t rec;
        if (has_b)
        begin
            pos  = 32'(msg_bits[8:3]);
            widx = pos >> 2;
            lane = pos & 3;
            if (lane == 0)
                msg_block[widx] = {b, 24'h0};
            else
                msg_block[widx] = msg_block[widx]
                    | (sha256_pkg::word_t'(b) << (24 - 8*lane));
            msg_bits = msg_bits + 64'd8;
            if (msg_bits == 64'd0)
                len_wrapped = 1'b1;
            bytes_hashed++;
            if (pos == 63)
                mix_block();
        end
        if (eom)
        begin
            // padding: marker byte, zeros, then the bit length
            pos  = 32'(msg_bits[8:3]);
            widx = pos >> 2;
            lane = pos & 3;
            if (lane == 0)
                msg_block[widx] = {sha256_pkg::PAD_MARKER, 24'h0};
            else
                msg_block[widx] = (msg_block[widx] & (32'hffff_ffff << (32 - 8*lane)))
                    | (sha256_pkg::word_t'(sha256_pkg::PAD_MARKER) << (24 - 8*lane));
            for (int i = widx + 1; i < 16; i++)
            begin
                msg_block[i] = '0;
            end
            // no room for the length: an extra block
            if (pos >= 56)
            begin
                mix_block();
                for (int i = 0; i < 14; i++)
                begin
                    msg_block[i] = '0;
                end
            end
            msg_block[14] = msg_bits[63:32];
            msg_block[15] = msg_bits[31:0];
            mix_block();
            for (int i = 0; i < 8; i++)
            begin
                rec.value    = hash_chain[i];
                rec.index    = sha256_pkg::dig_index_t'(i);
                rec.last     = (i == 7);
                rec.too_long = len_wrapped;
                digest_expect_q = {digest_expect_q, rec};
            end
            digests_made++;
            load_iv();
        end
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_word(sha256_pkg::byte_t b, logic has_b, logic eom);
        msg_word_t w;
        w.data     = b;
        w.has_byte = has_b;
        w.eom      = eom;
        pending_words = {pending_words, w};
        // idle words do nothing in the core, so they do not count
        if (has_b || eom)
            queued_words++;
    endtask

    // a whole message of random bytes, with the odd idle word mixed in;
    // the end mark rides on the last byte or comes as a word of its own
    task automatic queue_message(int unsigned n_bytes);
        bit split_end;
        split_end = ($urandom_range(0, 3) == 0) || (n_bytes == 0);
        for (int unsigned i = 0; i < n_bytes; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                push_word(sha256_pkg::byte_t'($urandom), 1'b0, 1'b0);
            push_word(sha256_pkg::byte_t'($urandom), 1'b1,
                      !split_end && (i == n_bytes - 1));
        end
        if (split_end)
            push_word(sha256_pkg::byte_t'($urandom), 1'b0, 1'b1);
    endtask

    // hold off until the core has nothing queued, nothing on the bus and
    // no digest word owed
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_words.size() != 0 || msg_ch.valid || digest_expect_q.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever
            #4 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // byte-side driver: new word at the falling edge, handshake at the rising
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && msg_ch.valid && msg_ch.ready)
        begin
            absorb_word(msg_ch.data_byte, msg_ch.byte_valid, msg_ch.end_of_message);
            msg_word_taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        msg_word_t w;
        if (!rst_n)
        begin
            msg_ch.valid <= 1'b0;
        end
        else if (!msg_ch.valid || msg_word_taken)
        begin
            // present the next word unless this cycle is a random gap
            if (pending_words.size() != 0 && $urandom_range(0, 99) >= idle_pct)
            begin
                w = pending_words.pop_front();
                msg_ch.valid          <= 1'b1;
                msg_ch.data_byte      <= w.data;
                msg_ch.byte_valid     <= w.has_byte;
                msg_ch.end_of_message <= w.eom;
            end
            else
            begin
                msg_ch.valid <= 1'b0;
            end
        end
        msg_word_taken = 1'b0;
    end

    // ------------------------------------------------------------------------
    // digest-side monitor: random stalls, check every accepted word
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        dig_ch.ready <= rst_n && ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        digest_rec_t exp_rec;
        if (rst_n && dig_ch.valid && dig_ch.ready)
        begin
            if (digest_expect_q.size() == 0)
            begin
                $error("unexpected digest word %h at index %0d",
                       dig_ch.digest_word, dig_ch.word_index);
                fails++;
            end
            else
            begin
                exp_rec = digest_expect_q.pop_front();
                words_checked++;
                if (dig_ch.digest_word !== exp_rec.value)
                begin
                    $error("digest_word: expected %h, got %h",
                           exp_rec.value, dig_ch.digest_word);
                    fails++;
                end
                if (dig_ch.word_index !== exp_rec.index)
                begin
                    $error("word_index: expected %0d, got %0d",
                           exp_rec.index, dig_ch.word_index);
                    fails++;
                end
                if (dig_ch.last_word !== exp_rec.last)
                begin
                    $error("last_word: expected %b, got %b",
                           exp_rec.last, dig_ch.last_word);
                    fails++;
                end
                if (dig_ch.too_long !== exp_rec.too_long)
                begin
                    $error("too_long: expected %b, got %b",
                           exp_rec.too_long, dig_ch.too_long);
                    fails++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned phase_start;
        int unsigned n_bytes;
        int unsigned idle_set  [4];
        int unsigned stall_set [4];

        // phases: no idling, sender gaps, receiver stalls, both together
        idle_set  = '{0, 63, 0, 22};
        stall_set = '{0, 0, 63, 22};

        rst_n                 = 1'b0;
        msg_ch.valid          = 1'b0;
        msg_ch.data_byte      = '0;
        msg_ch.byte_valid     = 1'b0;
        msg_ch.end_of_message = 1'b0;
        dig_ch.ready          = 1'b0;
        msg_word_taken        = 1'b0;
        idle_pct              = 0;
        stall_pct             = 0;
        queued_words          = 0;
        bytes_hashed          = 0;
        digests_made          = 0;
        words_checked         = 0;
        fails                 = 0;
        load_iv();
        for (int i = 0; i < 16; i++)
        begin
            msg_block[i] = '0;
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty message
        push_word(8'h00, 1'b0, 1'b1);
        // an idle word is ignored, then a lone 0xff byte with the end mark
        push_word(8'h5a, 1'b0, 1'b0);
        push_word(8'hff, 1'b1, 1'b1);
        // two bytes, an idle word, then the end mark on a word of its own
        push_word(8'h00, 1'b1, 1'b0);
        push_word(8'h80, 1'b1, 1'b0);
        push_word(8'h3c, 1'b0, 1'b0);
        push_word(8'hc3, 1'b0, 1'b1);
        // the classic three-byte message
        push_word(8'h61, 1'b1, 1'b0);
        push_word(8'h62, 1'b1, 1'b0);
        push_word(8'h63, 1'b1, 1'b1);
        // two empty messages back to back, state must be clean each time
        push_word(8'hff, 1'b0, 1'b1);
        push_word(8'h00, 1'b0, 1'b1);

        // sender holds off until every digest word is home
        wait_drained();

        // random messages: mostly short, some right on the padding edges
        for (int p = 0; p < 4; p++)
        begin
            idle_pct    = idle_set[p];
            stall_pct   = stall_set[p];
            phase_start = queued_words;
            while (queued_words - phase_start < PHASE_WORDS)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    n_bytes = $urandom_range(0, 20);
                end
                else
                begin
                    case ($urandom_range(0, 5))
                        0:       n_bytes = 55;
                        1:       n_bytes = 56;
                        2:       n_bytes = 57;
                        3:       n_bytes = 63;
                        4:       n_bytes = 64;
                        default: n_bytes = 65;
                    endcase
                end
                queue_message(n_bytes);
            end
            wait_drained();
        end

        // let any stray digest word show itself
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d messages (%0d bytes) over four idling phases",
                 digests_made, bytes_hashed);
        $display("checked %0d digest words, %0d mismatches", words_checked, fails);
        if (fails == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// File: files.f
design/sha256_pkg.sv
design/sha256_ifs.sv
design/sha256_message_digest_core.sv
design/sha256_chk.sv
tb/tb_top.sv
